>>> design/tcce_pkg.sv
// Shared types, constants and helpers for the text console cursor engine.
// No dependencies; every other design file refers to this package by scope.

package tcce_pkg;

    // Glyph cell geometry and tab expansion
    localparam int GLYPH_WIDTH  = 8;
    localparam int GLYPH_HEIGHT = 16;
    localparam int TAB_SPACES   = 4;

    // Field widths
    localparam int COORD_BITS = 12;
    localparam int SCALE_BITS = 5;
    localparam int COLOR_BITS = 24;
    localparam int CHAR_BITS  = 8;
    localparam int OP_BITS    = 2;

    // Glyph repeat count (one for a printable, TAB_SPACES for a tab)
    localparam int CNT_BITS = $clog2(TAB_SPACES + 1);

    // Command queue between front and back; depth is a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Register port
    localparam int ADDR_BITS    = 5;
    localparam int DATA_BITS    = 32;
    localparam int REG_IDX_BITS = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_DISP_WIDTH  = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_DISP_HEIGHT = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_FONT_SCALE  = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_INK_COLOR   = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_TEXT_ENABLE = 3'd4;

    // Register reset values
    localparam logic [COORD_BITS-1:0] RST_DISP_WIDTH  = 12'd1024;
    localparam logic [COORD_BITS-1:0] RST_DISP_HEIGHT = 12'd768;
    localparam logic [SCALE_BITS-1:0] RST_FONT_SCALE  = 5'd1;
    localparam logic [COLOR_BITS-1:0] RST_INK_COLOR   = 24'hFFFFFF;
    localparam logic                  RST_TEXT_ENABLE = 1'b1;

    // Result op codes
    localparam logic [OP_BITS-1:0] OP_DRAW  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_ERASE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

    // Input command codes
    localparam logic CMD_CHAR  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Character codes
    localparam logic [CHAR_BITS-1:0] CHR_BS      = 8'd8;
    localparam logic [CHAR_BITS-1:0] CHR_TAB     = 8'd9;
    localparam logic [CHAR_BITS-1:0] CHR_NL      = 8'd10;
    localparam logic [CHAR_BITS-1:0] CHR_SPACE   = 8'd32;
    localparam logic [CHAR_BITS-1:0] FIRST_PRINT = 8'd32;
    localparam logic [CHAR_BITS-1:0] LAST_PRINT  = 8'd126;

    typedef struct packed {
        logic                  cmd;
        logic [CHAR_BITS-1:0]  char_code;
        logic [COLOR_BITS-1:0] clear_color;
    } item_t;

    typedef struct packed {
        logic [OP_BITS-1:0]    op;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [CHAR_BITS-1:0]  glyph;
        logic [COLOR_BITS-1:0] paint_color;
        logic                  last;
    } res_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] disp_width;
        logic [COORD_BITS-1:0] disp_height;
        logic [SCALE_BITS-1:0] font_scale;
        logic [COLOR_BITS-1:0] ink_color;
        logic                  text_enable;
    } cfg_t;

    // Command classes handed from front to back
    typedef enum logic [1:0] {
        K_CLEAR     = 2'd0,
        K_NEWLINE   = 2'd1,
        K_BACKSPACE = 2'd2,
        K_GLYPH     = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [CHAR_BITS-1:0]  glyph;
        logic [CNT_BITS-1:0]   count;
        logic [COLOR_BITS-1:0] color;
    } entry_t;

    // Cell width and height in pixels for a given scale
    function automatic logic [COORD_BITS-1:0] cell_w(input logic [SCALE_BITS-1:0] scale);
        return COORD_BITS'(scale * GLYPH_WIDTH);
    endfunction

    function automatic logic [COORD_BITS-1:0] cell_h(input logic [SCALE_BITS-1:0] scale);
        return COORD_BITS'(scale * GLYPH_HEIGHT);
    endfunction

endpackage

>>> design/tcce_cfg.sv
// Configuration registers behind the APB-style port.
// Depends on tcce_pkg for register indexes, reset values and cfg_t.

module tcce_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcce_pkg::ADDR_BITS-1:0] paddr,
    input  logic [tcce_pkg::DATA_BITS-1:0] pwdata,
    output logic [tcce_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output tcce_pkg::cfg_t                 cfg
);

    logic [tcce_pkg::COORD_BITS-1:0]   width_reg;
    logic [tcce_pkg::COORD_BITS-1:0]   height_reg;
    logic [tcce_pkg::SCALE_BITS-1:0]   scale_reg;
    logic [tcce_pkg::COLOR_BITS-1:0]   color_reg;
    logic                              enable_reg;
    logic [tcce_pkg::REG_IDX_BITS-1:0] reg_idx;
    logic                              wr_en;

    assign reg_idx = paddr[tcce_pkg::ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Write the addressed register on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= tcce_pkg::RST_DISP_WIDTH;
            height_reg <= tcce_pkg::RST_DISP_HEIGHT;
            scale_reg  <= tcce_pkg::RST_FONT_SCALE;
            color_reg  <= tcce_pkg::RST_INK_COLOR;
            enable_reg <= tcce_pkg::RST_TEXT_ENABLE;
        end else if (wr_en) begin
            unique case (reg_idx)
                tcce_pkg::REG_DISP_WIDTH:  width_reg  <= pwdata[tcce_pkg::COORD_BITS-1:0];
                tcce_pkg::REG_DISP_HEIGHT: height_reg <= pwdata[tcce_pkg::COORD_BITS-1:0];
                tcce_pkg::REG_FONT_SCALE:  scale_reg  <= pwdata[tcce_pkg::SCALE_BITS-1:0];
                tcce_pkg::REG_INK_COLOR:   color_reg  <= pwdata[tcce_pkg::COLOR_BITS-1:0];
                tcce_pkg::REG_TEXT_ENABLE: enable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            tcce_pkg::REG_DISP_WIDTH:  prdata = tcce_pkg::DATA_BITS'(width_reg);
            tcce_pkg::REG_DISP_HEIGHT: prdata = tcce_pkg::DATA_BITS'(height_reg);
            tcce_pkg::REG_FONT_SCALE:  prdata = tcce_pkg::DATA_BITS'(scale_reg);
            tcce_pkg::REG_INK_COLOR:   prdata = tcce_pkg::DATA_BITS'(color_reg);
            tcce_pkg::REG_TEXT_ENABLE: prdata = tcce_pkg::DATA_BITS'(enable_reg);
            default:                   prdata = '0;
        endcase
    end

    assign cfg.disp_width  = width_reg;
    assign cfg.disp_height = height_reg;
    assign cfg.font_scale  = scale_reg;
    assign cfg.ink_color   = color_reg;
    assign cfg.text_enable = enable_reg;

endmodule

>>> design/tcce_front.sv
// Front end: accepts input items and classifies them into queue entries.
// Depends on tcce_pkg for item_t, entry_t and the character codes.

module tcce_front (
    input  logic             s_valid,
    output logic             s_ready,
    input  tcce_pkg::item_t  s_data,
    input  logic             text_enable,
    input  logic             q_full,
    output logic             q_push,
    output tcce_pkg::entry_t q_entry
);

    logic keep;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready && keep;

    // Classify the item; drop codes that cause no work
    always_comb begin
        keep          = 1'b0;
        q_entry.kind  = tcce_pkg::K_GLYPH;
        q_entry.glyph = s_data.char_code;
        q_entry.count = tcce_pkg::CNT_BITS'(1);
        q_entry.color = s_data.clear_color;
        if (s_data.cmd == tcce_pkg::CMD_CLEAR) begin
            q_entry.kind = tcce_pkg::K_CLEAR;
            keep         = 1'b1;
        end else if (text_enable) begin
            if (s_data.char_code == tcce_pkg::CHR_NL) begin
                q_entry.kind = tcce_pkg::K_NEWLINE;
                keep         = 1'b1;
            end else if (s_data.char_code == tcce_pkg::CHR_BS) begin
                q_entry.kind = tcce_pkg::K_BACKSPACE;
                keep         = 1'b1;
            end else if (s_data.char_code == tcce_pkg::CHR_TAB) begin
                q_entry.glyph = tcce_pkg::CHR_SPACE;
                q_entry.count = tcce_pkg::CNT_BITS'(tcce_pkg::TAB_SPACES);
                keep          = 1'b1;
            end else if (s_data.char_code >= tcce_pkg::FIRST_PRINT &&
                         s_data.char_code <= tcce_pkg::LAST_PRINT) begin
                keep = 1'b1;
            end
        end
    end

endmodule

>>> design/tcce_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on tcce_pkg for entry_t and the queue depth.

module tcce_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tcce_pkg::entry_t push_entry,
    input  logic             pop,
    output logic             q_valid,
    output logic             q_full,
    output tcce_pkg::entry_t head
);

    tcce_pkg::entry_t                 slot_reg [tcce_pkg::QUEUE_DEPTH];
    logic [tcce_pkg::QPTR_BITS-1:0]   wr_ptr_reg;
    logic [tcce_pkg::QPTR_BITS-1:0]   rd_ptr_reg;
    logic [tcce_pkg::QCNT_BITS-1:0]   count_reg;

    assign q_valid = count_reg != '0;
    assign q_full  = count_reg == tcce_pkg::QCNT_BITS'(tcce_pkg::QUEUE_DEPTH);
    assign head    = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + tcce_pkg::QPTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + tcce_pkg::QPTR_BITS'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + tcce_pkg::QCNT_BITS'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - tcce_pkg::QCNT_BITS'(1);
            end
        end
    end

    // Hold entries
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> design/tcce_back.sv
// Back end: owns the cursor and background, turns queue entries into render
// commands one per cycle unless m_ready stalls, held in the output register.
// Depends on tcce_pkg for entry_t, res_t, cfg_t and the op codes.

module tcce_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  tcce_pkg::cfg_t   cfg,
    input  logic             q_valid,
    input  tcce_pkg::entry_t head,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output tcce_pkg::res_t   m_data
);

    localparam int CB = tcce_pkg::COORD_BITS;

    typedef enum logic [2:0] {
        S_FETCH = 3'b001,
        S_GLYPH = 3'b010,
        S_DRAW0 = 3'b100
    } bstate_t;

    bstate_t                           state_reg, state_next;
    logic [CB-1:0]                     x_reg, x_next;
    logic [CB-1:0]                     y_reg, y_next;
    logic [tcce_pkg::COLOR_BITS-1:0]   bg_reg, bg_next;
    logic [tcce_pkg::CHAR_BITS-1:0]    glyph_reg, glyph_next;
    logic [tcce_pkg::CNT_BITS-1:0]     rem_reg, rem_next;
    logic                              m_valid_reg;
    tcce_pkg::res_t                    m_data_reg;

    logic [CB-1:0]                     cw, ch;
    logic                              step_ok;
    logic                              emit;
    tcce_pkg::res_t                    res;
    logic                              glyph_step;
    logic [tcce_pkg::CHAR_BITS-1:0]    g_code;
    logic [tcce_pkg::CNT_BITS-1:0]     g_rem;

    logic [CB:0]                       x_end, y_step, wy_end, nl_end;
    logic                              wrap, g_clear, nl_clear;
    logic [CB-1:0]                     wx, wy, y_nl;
    logic                              bs_home, bs_emit;
    logic [CB-1:0]                     bx, by;

    assign cw      = tcce_pkg::cell_w(cfg.font_scale);
    assign ch      = tcce_pkg::cell_h(cfg.font_scale);
    assign step_ok = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Glyph source: queue head on fetch, held copy while a tab runs
    assign g_code = (state_reg == S_FETCH) ? head.glyph : glyph_reg;
    assign g_rem  = (state_reg == S_FETCH) ? head.count : rem_reg;

    // Wrap to the next line, then test the bottom edge
    assign x_end   = {1'b0, x_reg} + {1'b0, cw};
    assign wrap    = x_end >= {1'b0, cfg.disp_width};
    assign y_step  = {1'b0, y_reg} + {1'b0, ch};
    assign y_nl    = y_step[CB-1:0];
    assign wx      = wrap ? '0 : x_reg;
    assign wy      = wrap ? y_nl : y_reg;
    assign wy_end  = {1'b0, wy} + {1'b0, ch};
    assign g_clear = wy_end >= {1'b0, cfg.disp_height};
    assign nl_end  = {1'b0, y_nl} + {1'b0, ch};
    assign nl_clear = nl_end >= {1'b0, cfg.disp_height};

    // Backspace: step back one cell, or to the end of the line above
    assign bs_home = (x_reg == '0) && (y_reg == '0);
    always_comb begin
        if (x_reg == '0) begin
            by = (y_reg > ch) ? y_reg - ch : '0;
            bx = (cfg.disp_width > cw) ? cfg.disp_width - cw : '0;
        end else begin
            bx = (x_reg > cw) ? x_reg - cw : '0;
            by = y_reg;
        end
    end
    assign bs_emit = !bs_home &&
                     ({1'b0, bx} + {1'b0, cw}) <= {1'b0, cfg.disp_width} &&
                     ({1'b0, by} + {1'b0, ch}) <= {1'b0, cfg.disp_height};

    // Sequence one result per cycle while the output register can take it
    always_comb begin
        state_next      = state_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        bg_next         = bg_reg;
        glyph_next      = glyph_reg;
        rem_next        = rem_reg;
        pop             = 1'b0;
        emit            = 1'b0;
        glyph_step      = 1'b0;
        res.op          = tcce_pkg::OP_CLEAR;
        res.pos_x       = '0;
        res.pos_y       = '0;
        res.glyph       = '0;
        res.paint_color = bg_reg;
        res.last        = 1'b1;

        unique case (state_reg)
            S_FETCH: begin
                if (q_valid && step_ok) begin
                    pop = 1'b1;
                    unique case (head.kind)
                        tcce_pkg::K_CLEAR: begin
                            emit            = 1'b1;
                            res.paint_color = head.color;
                            if (cfg.text_enable) begin
                                bg_next = head.color;
                                x_next  = '0;
                                y_next  = '0;
                            end
                        end
                        tcce_pkg::K_NEWLINE: begin
                            x_next = '0;
                            if (nl_clear) begin
                                emit   = 1'b1;
                                y_next = '0;
                            end else begin
                                y_next = y_nl;
                            end
                        end
                        tcce_pkg::K_BACKSPACE: begin
                            if (!bs_home) begin
                                x_next = bx;
                                y_next = by;
                            end
                            if (bs_emit) begin
                                emit      = 1'b1;
                                res.op    = tcce_pkg::OP_ERASE;
                                res.pos_x = bx;
                                res.pos_y = by;
                            end
                        end
                        tcce_pkg::K_GLYPH: begin
                            glyph_step = 1'b1;
                        end
                    endcase
                end
            end
            S_GLYPH: begin
                if (step_ok) begin
                    glyph_step = 1'b1;
                end
            end
            S_DRAW0: begin
                if (step_ok) begin
                    emit            = 1'b1;
                    res.op          = tcce_pkg::OP_DRAW;
                    res.glyph       = glyph_reg;
                    res.paint_color = cfg.ink_color;
                    res.last        = rem_reg == tcce_pkg::CNT_BITS'(1);
                    x_next          = cw;
                    y_next          = '0;
                    if (rem_reg > tcce_pkg::CNT_BITS'(1)) begin
                        rem_next   = rem_reg - tcce_pkg::CNT_BITS'(1);
                        state_next = S_GLYPH;
                    end else begin
                        state_next = S_FETCH;
                    end
                end
            end
            default: state_next = S_FETCH;
        endcase

        // Put one glyph: clear first when the line reaches the bottom
        if (glyph_step) begin
            glyph_next = g_code;
            emit       = 1'b1;
            if (g_clear) begin
                res.last   = 1'b0;
                x_next     = '0;
                y_next     = '0;
                rem_next   = g_rem;
                state_next = S_DRAW0;
            end else begin
                res.op          = tcce_pkg::OP_DRAW;
                res.pos_x       = wx;
                res.pos_y       = wy;
                res.glyph       = g_code;
                res.paint_color = cfg.ink_color;
                res.last        = g_rem == tcce_pkg::CNT_BITS'(1);
                x_next          = wx + cw;
                y_next          = wy;
                if (g_rem > tcce_pkg::CNT_BITS'(1)) begin
                    rem_next   = g_rem - tcce_pkg::CNT_BITS'(1);
                    state_next = S_GLYPH;
                end else begin
                    state_next = S_FETCH;
                end
            end
        end
    end

    // Cursor, background and sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_FETCH;
            x_reg     <= '0;
            y_reg     <= '0;
            bg_reg    <= '0;
        end else begin
            state_reg <= state_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            bg_reg    <= bg_next;
        end
    end

    always_ff @(posedge aclk) begin
        glyph_reg <= glyph_next;
        rem_reg   <= rem_next;
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= res;
        end
    end

endmodule

>>> design/text_console_cursor_engine_core.sv
// Text console cursor engine: top level joining register port, front end,
// command queue and back end. Depends on tcce_pkg and all tcce_* modules.
//
// Usage:
//   s_* channel takes one item: a character (cmd 0) or a clear (cmd 1).
//   m_* channel gives render commands: draw glyph, erase cell, clear screen;
//   last marks the final command caused by an item. Items that cause nothing
//   (ignored codes, text mode off, newline without a clear) give no result.
//   The APB-style port holds screen size, font scale, font colour and the
//   text enable; write it only while no item is in flight.
// Path: an accepted item is written into the queue; the back end fetches it
//   from the queue head and loads its first result into the output register.
// Throughput: one item per cycle for a printable, newline, backspace or
//   clear while m_ready keeps the output register free; a printable that
//   hits the bottom edge gives a clear, then a draw; a tab gives four space
//   draws. The back end's single result per cycle sets this rate.
// Reset: cursor at the origin, background black, registers at their reset
//   values, queue and output register empty.
// Stall: when m_ready is low the output register holds its command, the
//   back end waits, the two-entry queue fills and then s_ready falls.

module text_console_cursor_engine_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tcce_pkg::item_t                s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tcce_pkg::res_t                 m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcce_pkg::ADDR_BITS-1:0] paddr,
    input  logic [tcce_pkg::DATA_BITS-1:0] pwdata,
    output logic [tcce_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready
);

    tcce_pkg::cfg_t   cfg;
    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_valid;
    tcce_pkg::entry_t q_entry;
    tcce_pkg::entry_t q_head;

    tcce_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcce_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .text_enable (cfg.text_enable),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    tcce_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .q_full     (q_full),
        .head       (q_head)
    );

    tcce_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (q_valid),
        .head    (q_head),
        .pop     (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_clear_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.op == tcce_pkg::OP_CLEAR |->
            m_data.pos_x == '0 && m_data.pos_y == '0 && m_data.glyph == '0)
        else $error("clear command carries a position or glyph");

    a_draw_color: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.op == tcce_pkg::OP_DRAW |->
            m_data.paint_color == cfg.ink_color)
        else $error("draw command not in font colour");

    a_erase_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.op == tcce_pkg::OP_ERASE |->
            ({1'b0, m_data.pos_x} + {1'b0, tcce_pkg::cell_w(cfg.font_scale)})
                <= {1'b0, cfg.disp_width})
        else $error("erase cell beyond right edge");
`endif

endmodule
